/* rtl/dvru_pkg.sv */
package dvru_pkg;

  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int ID_W      = 8;
  localparam int IN_DIST_W = 16;
  localparam int CNT_W     = 9;
  localparam int CFG_W     = 4;

  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  localparam logic [OP_W-1:0] OP_LOAD_ROUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_NBR   = 2'd1;
  localparam logic [OP_W-1:0] OP_VECTOR     = 2'd2;

  localparam logic CFG_ROUTER_COUNT   = 1'b0;
  localparam logic CFG_NEIGHBOR_COUNT = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_route;
    logic load_nbr;
    logic nscan;
    logic rscan;
    logic emit;
  } dvru_cmd_t;

  typedef struct packed {
    logic nbr_empty;
    logic nbr_hit;
    logic nbr_miss;
    logic sender_valid;
    logic route_done;
    logic last;
  } dvru_sts_t;

endpackage

/* rtl/dvru_ram.sv */
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dvru_ctrl.sv */
module dvru_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [dvru_pkg::OP_W-1:0]    op_i,
  input  logic                         first_entry_i,
  input  logic                         out_ready_i,
  input  dvru_pkg::dvru_sts_t          sts_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output dvru_pkg::dvru_cmd_t          cmd_o
);
  import dvru_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_NSCAN = 2'd1;
  localparam logic [1:0] ST_RSCAN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    accept  = in_valid_i && (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD_ROUTE: cmd_o.load_route = 1'b1;
            OP_LOAD_NBR:   cmd_o.load_nbr = 1'b1;
            OP_VECTOR: begin
              cmd_o.capture = 1'b1;
              if (first_entry_i) begin
                state_d = sts_i.nbr_empty ? ST_FIN : ST_NSCAN;
              end else begin
                state_d = sts_i.sender_valid ? ST_RSCAN : ST_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_NSCAN: begin
        cmd_o.nscan = 1'b1;
        if (sts_i.nbr_hit) begin
          state_d = ST_RSCAN;
        end else if (sts_i.nbr_miss) begin
          state_d = ST_FIN;
        end
      end
      ST_RSCAN: begin
        cmd_o.rscan = 1'b1;
        if (sts_i.route_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // A last entry waits here until the output register is free.
        if (!sts_i.last) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/dvru_dp.sv */
module dvru_dp #(
  parameter int MAX_ROUTES    = 16,
  parameter int MAX_NEIGHBORS = 8,
  parameter int DIST_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [dvru_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [dvru_pkg::SLOT_W-1:0]     slot_i,
  input  logic [dvru_pkg::ID_W-1:0]       router_id_i,
  input  logic [dvru_pkg::ID_W-1:0]       hop_id_i,
  input  logic [dvru_pkg::IN_DIST_W-1:0]  distance_i,
  input  logic                            first_entry_i,
  input  logic                            last_entry_i,
  input  dvru_pkg::dvru_cmd_t             cmd_i,
  output dvru_pkg::dvru_sts_t             sts_o,
  output logic [dvru_pkg::CNT_W-1:0]      change_count_o,
  output logic                            unknown_neighbor_o
);
  import dvru_pkg::*;

  localparam int RAW = $clog2(MAX_ROUTES);
  localparam int NAW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int NCW = $clog2(MAX_NEIGHBORS + 1);
  localparam int RW  = 2 * ID_W + DIST_BITS;
  localparam int NW  = ID_W + DIST_BITS;
  localparam logic [DIST_BITS-1:0] DIST_TOP = '1;

  // Configuration registers.
  logic [CFG_W-1:0] router_count_q, neighbor_count_q;
  logic [NCW-1:0]   nbr_n;
  logic [RAW-1:0]   route_top;

  // Captured vector entry.
  logic [ID_W-1:0]      rid_q, rid_d, hid_q, hid_d;
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic                 last_q, last_d;

  // Sender and counting state.
  logic [DIST_BITS-1:0] weight_q, weight_d;
  logic                 sender_valid_q, sender_valid_d;
  logic [CNT_W-1:0]     changes_q, changes_d;

  // Scan pointers: one read issued per cycle, checked the cycle after.
  logic [NCW-1:0] nb_iss_q, nb_iss_d;
  logic           nb_chk_q, nb_chk_d, nb_chk_last_q, nb_chk_last_d;
  logic [RAW:0]   rt_iss_q, rt_iss_d;
  logic           rt_chk_q, rt_chk_d, rt_chk_last_q, rt_chk_last_d;
  logic [RAW-1:0] rt_chk_addr_q, rt_chk_addr_d;

  logic [CNT_W-1:0] out_count_q, out_count_d;
  logic             out_unknown_q, out_unknown_d;

  logic [DIST_BITS-1:0] dist_c;
  logic [DIST_BITS:0]   sum_w;
  logic [DIST_BITS-1:0] sum;
  logic [NW-1:0]        nb_rdata, nb_wdata;
  logic                 nb_we;
  logic [RW-1:0]        rt_rdata, rt_wdata;
  logic                 rt_we, rt_wr;
  logic [RAW-1:0]       rt_waddr;
  logic [ID_W-1:0]      rt_dest;
  logic [DIST_BITS-1:0] rt_dist;
  logic                 nb_hit, nb_miss, route_done;

  if (DIST_BITS >= IN_DIST_W) begin : g_dist_wide
    assign dist_c = DIST_BITS'(distance_i);
  end else begin : g_dist_narrow
    assign dist_c = (distance_i > IN_DIST_W'(DIST_TOP)) ? DIST_TOP
                                                        : distance_i[DIST_BITS-1:0];
  end

  always_comb begin
    if (int'(neighbor_count_q) > MAX_NEIGHBORS) begin
      nbr_n = NCW'(MAX_NEIGHBORS);
    end else begin
      nbr_n = NCW'(neighbor_count_q);
    end
    if (int'(router_count_q) > MAX_ROUTES - 1) begin
      route_top = RAW'(MAX_ROUTES - 1);
    end else begin
      route_top = RAW'(router_count_q);
    end
  end

  assign sum_w = {1'b0, weight_q} + {1'b0, dist_q};
  assign sum   = sum_w[DIST_BITS] ? DIST_TOP : sum_w[DIST_BITS-1:0];

  // Neighbor table: {id, weight}.
  assign nb_we    = cmd_i.load_nbr && (int'(slot_i) < MAX_NEIGHBORS);
  assign nb_wdata = {router_id_i, dist_c};

  dvru_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_NEIGHBORS)
  ) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (NAW'(slot_i)),
    .wdata_i (nb_wdata),
    .raddr_i (nb_iss_q[NAW-1:0]),
    .rdata_o (nb_rdata)
  );

  assign nb_hit  = cmd_i.nscan && nb_chk_q && (nb_rdata[NW-1 -: ID_W] == rid_q);
  assign nb_miss = cmd_i.nscan && nb_chk_q && !nb_hit && nb_chk_last_q;

  // Routing table: {dest, next hop, distance}.
  assign rt_dest    = rt_rdata[RW-1 -: ID_W];
  assign rt_dist    = rt_rdata[DIST_BITS-1:0];
  assign rt_wr      = cmd_i.rscan && rt_chk_q && (rt_dest == rid_q) && (rt_dist > sum);
  assign route_done = cmd_i.rscan && rt_chk_q && rt_chk_last_q;

  always_comb begin
    if (cmd_i.load_route) begin
      rt_we    = (int'(slot_i) < MAX_ROUTES);
      rt_waddr = RAW'(slot_i);
      rt_wdata = {router_id_i, hop_id_i, dist_c};
    end else begin
      rt_we    = rt_wr;
      rt_waddr = rt_chk_addr_q;
      rt_wdata = {rt_dest, hid_q, sum};
    end
  end

  dvru_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROUTES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (rt_iss_q[RAW-1:0]),
    .rdata_o (rt_rdata)
  );

  always_comb begin
    rid_d          = rid_q;
    hid_d          = hid_q;
    dist_d         = dist_q;
    last_d         = last_q;
    weight_d       = weight_q;
    sender_valid_d = sender_valid_q;
    changes_d      = changes_q;
    nb_iss_d       = nb_iss_q;
    nb_chk_d       = nb_chk_q;
    nb_chk_last_d  = nb_chk_last_q;
    rt_iss_d       = rt_iss_q;
    rt_chk_d       = rt_chk_q;
    rt_chk_last_d  = rt_chk_last_q;
    rt_chk_addr_d  = rt_chk_addr_q;
    out_count_d    = out_count_q;
    out_unknown_d  = out_unknown_q;

    if (cmd_i.capture) begin
      rid_d    = router_id_i;
      hid_d    = hop_id_i;
      dist_d   = dist_c;
      last_d   = last_entry_i;
      nb_iss_d = '0;
      nb_chk_d = 1'b0;
      rt_iss_d = '0;
      rt_chk_d = 1'b0;
      if (first_entry_i) begin
        weight_d       = '0;
        sender_valid_d = 1'b0;
        changes_d      = '0;
      end
    end

    if (cmd_i.nscan) begin
      if (nb_iss_q < nbr_n) begin
        nb_iss_d      = nb_iss_q + NCW'(1);
        nb_chk_d      = 1'b1;
        nb_chk_last_d = ((nb_iss_q + NCW'(1)) == nbr_n);
      end else begin
        nb_chk_d = 1'b0;
      end
    end
    if (nb_hit) begin
      sender_valid_d = 1'b1;
      weight_d       = nb_rdata[DIST_BITS-1:0];
    end

    if (cmd_i.rscan) begin
      if (rt_iss_q <= {1'b0, route_top}) begin
        rt_iss_d      = rt_iss_q + (RAW+1)'(1);
        rt_chk_d      = 1'b1;
        rt_chk_addr_d = rt_iss_q[RAW-1:0];
        rt_chk_last_d = (rt_iss_q == {1'b0, route_top});
      end else begin
        rt_chk_d = 1'b0;
      end
    end
    if (rt_wr && (changes_q != CNT_TOP)) begin
      changes_d = changes_q + CNT_W'(1);
    end

    if (cmd_i.emit) begin
      out_count_d    = changes_q;
      out_unknown_d  = !sender_valid_q;
      changes_d      = '0;
      sender_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_count_q   <= '0;
      neighbor_count_q <= '0;
      weight_q         <= '0;
      sender_valid_q   <= 1'b0;
      changes_q        <= '0;
      nb_chk_q         <= 1'b0;
      rt_chk_q         <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_ROUTER_COUNT)) begin
        router_count_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_NEIGHBOR_COUNT)) begin
        neighbor_count_q <= cfg_wdata_i;
      end
      weight_q       <= weight_d;
      sender_valid_q <= sender_valid_d;
      changes_q      <= changes_d;
      nb_chk_q       <= nb_chk_d;
      rt_chk_q       <= rt_chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rid_q         <= rid_d;
    hid_q         <= hid_d;
    dist_q        <= dist_d;
    last_q        <= last_d;
    nb_iss_q      <= nb_iss_d;
    nb_chk_last_q <= nb_chk_last_d;
    rt_iss_q      <= rt_iss_d;
    rt_chk_last_q <= rt_chk_last_d;
    rt_chk_addr_q <= rt_chk_addr_d;
    out_count_q   <= out_count_d;
    out_unknown_q <= out_unknown_d;
  end

  always_comb begin
    sts_o              = '0;
    sts_o.nbr_empty    = (nbr_n == '0);
    sts_o.nbr_hit      = nb_hit;
    sts_o.nbr_miss     = nb_miss;
    sts_o.sender_valid = sender_valid_q;
    sts_o.route_done   = route_done;
    sts_o.last         = last_q;
  end

  assign change_count_o     = out_count_q;
  assign unknown_neighbor_o = out_unknown_q;

endmodule

/* rtl/distance_vector_route_update_top.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   op, slot, router_id, hop_id, distance,
//                                                first_entry, last_entry
// out       output     out_valid_o / out_ready_i change_count, unknown_neighbor
// cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Load beats write their table entry and leave the block idle. A vector beat from a known sender
// runs a route table scan that reads one entry per cycle from a RAM with separate read and
// write ports and writes back improved entries behind the read. A first entry adds a
// neighbor table lookup, which stops at the first match.
// Reset is asynchronous and clears control state; table contents are undefined until loaded.
// A finished result sits in an output register, so the next beat is taken while it waits;
// only a later last entry stalls until that register has been drained.
module distance_vector_route_update_top #(
  parameter int MAX_ROUTES    = 16,
  parameter int MAX_NEIGHBORS = 8,
  parameter int DIST_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [dvru_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dvru_pkg::OP_W-1:0]       op_i,
  input  logic [dvru_pkg::SLOT_W-1:0]     slot_i,
  input  logic [dvru_pkg::ID_W-1:0]       router_id_i,
  input  logic [dvru_pkg::ID_W-1:0]       hop_id_i,
  input  logic [dvru_pkg::IN_DIST_W-1:0]  distance_i,
  input  logic                            first_entry_i,
  input  logic                            last_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dvru_pkg::CNT_W-1:0]      change_count_o,
  output logic                            unknown_neighbor_o
);
  import dvru_pkg::*;

  dvru_cmd_t cmd;
  dvru_sts_t sts;

  dvru_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .first_entry_i (first_entry_i),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  dvru_dp #(
    .MAX_ROUTES    (MAX_ROUTES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .DIST_BITS     (DIST_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .slot_i             (slot_i),
    .router_id_i        (router_id_i),
    .hop_id_i           (hop_id_i),
    .distance_i         (distance_i),
    .first_entry_i      (first_entry_i),
    .last_entry_i       (last_entry_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .change_count_o     (change_count_o),
    .unknown_neighbor_o (unknown_neighbor_o)
  );

endmodule

/* tb/distance_vector_route_update_top_tb.sv */
`timescale 1ns / 1ps

module distance_vector_route_update_top_tb;
  import dvru_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_ROUTES = 16;
  localparam int NUM_NBRS = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [IN_DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      rid;
    logic [ID_W-1:0]      hid;
    logic [IN_DIST_W-1:0] metric;
    logic                 first;
    logic                 last;
  } beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] changes;
    logic             unknown;
  } route_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i = '0;
  logic [SLOT_W-1:0]    slot_i = '0;
  logic [ID_W-1:0]      router_id_i = '0;
  logic [ID_W-1:0]      hop_id_i = '0;
  logic [IN_DIST_W-1:0] distance_i = '0;
  logic                 first_entry_i = 1'b0;
  logic                 last_entry_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CNT_W-1:0]     change_count_o;
  logic                 unknown_neighbor_o;

  distance_vector_route_update_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .slot_i            (slot_i),
    .router_id_i       (router_id_i),
    .hop_id_i          (hop_id_i),
    .distance_i        (distance_i),
    .first_entry_i     (first_entry_i),
    .last_entry_i      (last_entry_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .change_count_o    (change_count_o),
    .unknown_neighbor_o(unknown_neighbor_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the routing and neighbor tables.
  logic [ID_W-1:0]      m_dest   [NUM_ROUTES];
  logic [ID_W-1:0]      m_hop    [NUM_ROUTES];
  logic [IN_DIST_W-1:0] m_dist   [NUM_ROUTES];
  logic [ID_W-1:0]      m_nbr_id [NUM_NBRS];
  logic [IN_DIST_W-1:0] m_nbr_wt [NUM_NBRS];
  logic [IN_DIST_W-1:0] m_weight = '0;
  logic [CNT_W-1:0]     m_changes = '0;
  bit                   m_sender_ok = 1'b0;
  logic [CFG_W-1:0]     m_route_top = '0;
  logic [CFG_W-1:0]     m_nbr_count = '0;

  route_report_t pending_reports[$];
  route_report_t next_report;
  int errors = 0;
  int beats_sent = 0;
  int reports_checked = 0;
  int rx_hold_len = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic [ID_W-1:0] dest_pool [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

  function automatic int active_nbrs();
    return (m_nbr_count > NUM_NBRS) ? NUM_NBRS : int'(m_nbr_count);
  endfunction

  // Applies one accepted beat to the shadow tables and queues the report it causes.
  function automatic void update_route_model(beat_t b);
    logic [IN_DIST_W:0] sum;
    case (b.op)
      OP_LOAD_ROUTE: begin
        m_dest[b.slot] = b.rid;
        m_hop[b.slot]  = b.hid;
        m_dist[b.slot] = b.metric;
      end
      OP_LOAD_NBR: begin
        if (b.slot < NUM_NBRS) begin
          m_nbr_id[b.slot[2:0]] = b.rid;
          m_nbr_wt[b.slot[2:0]] = b.metric;
        end
      end
      OP_VECTOR: begin
        if (b.first) begin
          m_changes   = '0;
          m_sender_ok = 1'b0;
          m_weight    = '0;
          // Walk downward so that the lowest matching slot is the one kept.
          for (int i = active_nbrs() - 1; i >= 0; i--) begin
            if (m_nbr_id[i] == b.rid) begin
              m_sender_ok = 1'b1;
              m_weight    = m_nbr_wt[i];
            end
          end
        end
        if (m_sender_ok) begin
          sum = {1'b0, b.metric} + {1'b0, m_weight};
          if (sum > {1'b0, DIST_MAX}) sum = {1'b0, DIST_MAX};
          for (int i = 0; i < NUM_ROUTES; i++) begin
            if (i <= m_route_top && m_dest[i] == b.rid && {1'b0, m_dist[i]} > sum) begin
              m_dist[i] = sum[IN_DIST_W-1:0];
              m_hop[i]  = b.hid;
              if (m_changes != CNT_TOP) m_changes = m_changes + CNT_W'(1);
            end
          end
        end
        if (b.last) begin
          pending_reports.push_back('{changes: m_changes, unknown: !m_sender_ok});
          m_changes   = '0;
          m_sender_ok = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic beat_t vec(logic [ID_W-1:0] rid, logic [ID_W-1:0] hid,
                                logic [IN_DIST_W-1:0] metric, logic first, logic last);
    return '{op: OP_VECTOR, slot: 4'($urandom_range(0, 15)), rid: rid, hid: hid,
             metric: metric, first: first, last: last};
  endfunction

  function automatic beat_t route_load(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] dest,
                                       logic [ID_W-1:0] hop, logic [IN_DIST_W-1:0] metric);
    return '{op: OP_LOAD_ROUTE, slot: slot, rid: dest, hid: hop, metric: metric,
             first: 1'($urandom_range(0, 1)), last: 1'($urandom_range(0, 1))};
  endfunction

  function automatic beat_t nbr_load(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                                     logic [IN_DIST_W-1:0] weight);
    return '{op: OP_LOAD_NBR, slot: slot, rid: id, hid: 8'($urandom_range(0, 255)),
             metric: weight, first: 1'($urandom_range(0, 1)),
             last: 1'($urandom_range(0, 1))};
  endfunction

  function automatic logic [ID_W-1:0] pick_dest();
    if ($urandom_range(0, 9) < 8) return dest_pool[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [IN_DIST_W-1:0] pick_dist();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 16'h7FFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_beat(input beat_t b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i          <= b.op;
    slot_i        <= b.slot;
    router_id_i   <= b.rid;
    hop_id_i      <= b.hid;
    distance_i    <= b.metric;
    first_entry_i <= b.first;
    last_entry_i  <= b.last;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    update_route_model(b);
    if (b.op != OP_UNUSED) beats_sent++;
  endtask

  // Waits until every report is in and the block has finished any report-less beat.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROUTER_COUNT) m_route_top = val;
    else m_nbr_count = val;
  endtask

  // Every table entry is written here, so no later lookup touches an unloaded slot.
  task automatic test_table_setup();
    set_reg(CFG_ROUTER_COUNT, 4'd15);
    set_reg(CFG_NEIGHBOR_COUNT, 4'd8);
    for (int i = 0; i < NUM_ROUTES; i++)
      send_beat(route_load(4'(i), dest_pool[i % 4], 8'($urandom_range(0, 255)), DIST_MAX));
    for (int i = 0; i < NUM_NBRS; i++)
      send_beat(nbr_load(4'(i), 8'(8'h10 + i), 16'(i * 3)));
    settle();
  endtask

  task automatic test_directed_vectors();
    // A vector entry with no opening entry since reset reports an unknown sender.
    send_beat(vec(8'h5A, 8'h01, 16'd100, 1'b0, 1'b1));
    send_beat(vec(8'h10, 8'h02, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h5A, 8'h03, 16'd1000, 1'b0, 1'b1));
    send_beat(vec(8'h11, 8'h04, 16'd0, 1'b1, 1'b1));
    send_beat(vec(8'h99, 8'h05, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h00, 8'h06, 16'd0, 1'b0, 1'b1));
    // Distance extremes, the larger one saturating the sum.
    send_beat(vec(8'h17, 8'hFF, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'hFF, 8'h00, 16'd0, 1'b0, 1'b0));
    send_beat(vec(8'hFF, 8'hFF, DIST_MAX, 1'b0, 1'b0));
    send_beat(vec(8'h00, 8'hAA, DIST_MAX, 1'b0, 1'b1));
    // A full-scale link weight saturates every sum.
    send_beat(nbr_load(4'd7, 8'h17, DIST_MAX));
    send_beat(vec(8'h17, 8'h07, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'hA5, 8'h08, 16'd1, 1'b0, 1'b1));
    // A duplicate neighbor id in a higher slot must lose to the lower one.
    send_beat(nbr_load(4'd5, 8'h12, DIST_MAX));
    send_beat(vec(8'h12, 8'h09, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'hA5, 8'h0A, 16'd7, 1'b0, 1'b1));
    // Neighbor loads past the table are dropped.
    send_beat(nbr_load(4'd12, 8'h77, 16'd0));
    send_beat(vec(8'h77, 8'h0B, 16'd0, 1'b1, 1'b1));
    send_beat('{op: OP_UNUSED, slot: '1, rid: '1, hid: '1, metric: '1, first: 1'b1,
                last: 1'b1});
    // A second opening entry restarts the count.
    send_beat(vec(8'h10, 8'h0C, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h00, 8'h0D, 16'd5, 1'b0, 1'b0));
    send_beat(vec(8'h11, 8'h0E, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h00, 8'h0F, 16'd1, 1'b0, 1'b1));
    send_beat(route_load(4'd15, 8'hFF, 8'hFF, 16'd0));
    settle();
  endtask

  // Sixteen matching routes improved on every entry push the count past its top.
  task automatic test_count_saturation();
    for (int i = 0; i < NUM_ROUTES; i++)
      send_beat(route_load(4'(i), 8'h3C, 8'h00, DIST_MAX));
    send_beat(nbr_load(4'd0, 8'h21, 16'd0));
    send_beat(vec(8'h21, 8'h00, 16'd0, 1'b1, 1'b0));
    for (int k = 1; k <= 34; k++)
      send_beat(vec(8'h3C, 8'(k), DIST_MAX - 16'(k), 1'b0, k == 34));
    settle();
  endtask

  task automatic test_config_extremes();
    set_reg(CFG_ROUTER_COUNT, 4'd0);
    set_reg(CFG_NEIGHBOR_COUNT, 4'd0);
    send_beat(vec(8'h21, 8'h01, 16'd0, 1'b1, 1'b1));
    settle();
    set_reg(CFG_NEIGHBOR_COUNT, 4'd15);
    send_beat(route_load(4'd0, 8'h44, 8'h01, DIST_MAX));
    send_beat(route_load(4'd1, 8'h44, 8'h01, DIST_MAX));
    send_beat(vec(8'h21, 8'h02, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h44, 8'h03, 16'd9, 1'b0, 1'b1));
    send_beat(vec(8'h17, 8'h04, 16'd0, 1'b1, 1'b1));
    settle();
    set_reg(CFG_NEIGHBOR_COUNT, 4'd9);
    set_reg(CFG_ROUTER_COUNT, 4'd1);
    send_beat(vec(8'h17, 8'h05, 16'd0, 1'b1, 1'b0));
    send_beat(vec(8'h44, 8'h06, 16'd2, 1'b0, 1'b1));
    settle();
    set_reg(CFG_ROUTER_COUNT, 4'd15);
    set_reg(CFG_NEIGHBOR_COUNT, 4'd8);
  endtask

  // The sink holds off long enough for reports to back up into the input.
  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    repeat (12)
      send_beat(vec(8'h21, 8'($urandom_range(0, 255)), pick_dist(), 1'b1, 1'b1));
    settle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int quota;
    int len;
    int pick;
    int n;
    logic [ID_W-1:0] sender;
    logic [CFG_W-1:0] rc;
    logic [CFG_W-1:0] nc;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: begin rc = 4'd15; nc = 4'd8;  end
        1: begin rc = 4'd0;  nc = 4'd1;  end
        2: begin rc = 4'd7;  nc = 4'd15; end
        default: begin
          rc = 4'($urandom_range(0, 15));
          nc = 4'($urandom_range(0, 15));
        end
      endcase
      set_reg(CFG_ROUTER_COUNT, rc);
      set_reg(CFG_NEIGHBOR_COUNT, nc);
      tx_idle_on = (phase != 3) && (phase != 6);
      rx_idle_on = (phase != 3) && (phase != 5);
      for (int k = 0; k < 4; k++) dest_pool[k] = 8'($urandom_range(0, 255));
      for (int i = 0; i < NUM_ROUTES; i++)
        send_beat(route_load(4'(i), dest_pool[i % 4], 8'($urandom_range(0, 255)),
                             16'($urandom_range(16'hC000, 16'hFFFF))));
      quota = beats_sent + 160;
      while (beats_sent < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          len = $urandom_range(1, 6);
          n = active_nbrs();
          if (n > 0 && $urandom_range(0, 3) != 0) sender = m_nbr_id[$urandom_range(0, n - 1)];
          else sender = 8'($urandom_range(0, 255));
          send_beat(vec(sender, 8'($urandom_range(0, 255)), pick_dist(), 1'b1, len == 1));
          for (int e = 1; e < len; e++)
            send_beat(vec(pick_dest(), 8'($urandom_range(0, 255)), pick_dist(), 1'b0,
                          e == len - 1));
        end else if (pick < 75) begin
          send_beat(route_load(4'($urandom_range(0, 15)), pick_dest(),
                               8'($urandom_range(0, 255)),
                               ($urandom_range(0, 9) < 7) ?
                                 16'($urandom_range(16'hC000, 16'hFFFF)) :
                                 16'($urandom_range(0, 16'hFFFF))));
        end else if (pick < 83) begin
          send_beat(nbr_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                             ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 16'h0FFF)) :
                                                           16'($urandom_range(0, 16'hFFFF))));
        end else if (pick < 90) begin
          send_beat('{op: OP_UNUSED, slot: 4'($urandom_range(0, 15)),
                      rid: 8'($urandom_range(0, 255)), hid: 8'($urandom_range(0, 255)),
                      metric: 16'($urandom_range(0, 16'hFFFF)),
                      first: 1'($urandom_range(0, 1)), last: 1'($urandom_range(0, 1))});
        end else begin
          send_beat(vec(pick_dest(), 8'($urandom_range(0, 255)), pick_dist(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
      end
    end
    settle();
  endtask

  initial begin : report_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        gap = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: change_count=%0d unknown_neighbor=%0b",
               change_count_o, unknown_neighbor_o);
        errors++;
      end else begin
        next_report = pending_reports.pop_front();
        reports_checked++;
        if (change_count_o !== next_report.changes) begin
          $error("change_count mismatch: expected %0d, actual %0d",
                 next_report.changes, change_count_o);
          errors++;
        end
        if (unknown_neighbor_o !== next_report.unknown) begin
          $error("unknown_neighbor mismatch: expected %0b, actual %0b",
                 next_report.unknown, unknown_neighbor_o);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d reports outstanding",
             cycles, pending_reports.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_table_setup();
    test_directed_vectors();
    test_count_saturation();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();
    settle();
    $display("Covered %0d beats and %0d change reports across table loads, unknown senders,",
             beats_sent, reports_checked);
    $display("count saturation, register extremes and a %0d-cycle output stall.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dvru_pkg.sv
rtl/dvru_ram.sv
rtl/dvru_ctrl.sv
rtl/dvru_dp.sv
rtl/distance_vector_route_update_top.sv
tb/distance_vector_route_update_top_tb.sv
